>>> sv/pcb_pkg.sv
package pcb_pkg;

  localparam int PROVIDERS_DEF = 16;
  localparam int TIME_W        = 32;
  localparam int PROV_W        = 4;
  localparam int PROV_SPAN     = 16;
  localparam int FAIL_W        = 16;
  localparam int NUM_CAND      = 5;
  localparam int CAND_W        = 3;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 20;
  localparam int SECS_W        = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BRK_MAX   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_MAX  = 3'd4;

  localparam logic [7:0]        THRESHOLD_RST = 8'd3;
  localparam logic [15:0]       BASE_RST      = 16'd30;
  localparam logic [SECS_W-1:0] BRK_MAX_RST   = 20'd600;
  localparam logic [SECS_W-1:0] FALLBACK_RST  = 20'd60;
  localparam logic [SECS_W-1:0] RATE_MAX_RST  = 20'd3600;

  localparam logic [1:0] ST_NONE  = 2'd0;
  localparam logic [1:0] ST_RATE  = 2'd1;
  localparam logic [1:0] ST_BREAK = 2'd2;

  localparam logic [2:0] CAUSE_NONE   = 3'd0;
  localparam logic [2:0] CAUSE_RETRY  = 3'd1;
  localparam logic [2:0] CAUSE_WINDOW = 3'd2;
  localparam logic [2:0] CAUSE_PLAIN  = 3'd3;
  localparam logic [2:0] CAUSE_FAIL   = 3'd4;

  localparam logic [1:0] KIND_REPORT = 2'd0;
  localparam logic [1:0] KIND_FAIL   = 2'd1;
  localparam logic [1:0] KIND_PASS   = 2'd2;
  localparam logic [1:0] KIND_QUERY  = 2'd3;

  localparam logic [FAIL_W-1:0] FAIL_MAX = 16'hFFFF;
  localparam logic [2:0]        ESC_MAX  = 3'd5;

  typedef struct packed {
    logic [1:0]        kind;
    logic [PROV_W-1:0] provider;
    logic [TIME_W-1:0] now;
    logic              limited;
    logic [SECS_W-1:0] retry_secs;
    logic [TIME_W-1:0] req_reset_at;
    logic [TIME_W-1:0] tok_reset_at;
    logic [1:0]        window_count;
    logic [TIME_W-1:0] first_window_reset;
    logic              first_window_full;
    logic [TIME_W-1:0] second_window_reset;
    logic              second_window_full;
  } in_t;

  typedef struct packed {
    logic [1:0]        entry_state;
    logic [TIME_W-1:0] entry_until;
    logic [FAIL_W-1:0] entry_failures;
    logic [2:0]        entry_cause;
    logic              soonest_valid;
    logic [TIME_W-1:0] soonest_until;
    logic [PROV_W-1:0] soonest_idx;
  } out_t;

  typedef struct packed {
    logic [1:0]        st;
    logic [TIME_W-1:0] deadline;
    logic [FAIL_W-1:0] fails;
    logic [2:0]        cause;
  } entry_t;

  typedef struct packed {
    logic              capture;
    logic              rd_entry;
    logic              prep;
    logic              fold;
    logic [CAND_W-1:0] fold_sel;
    logic              cap;
    logic              write;
    logic              scan_clr;
    logic              scan_rd;
  } cmd_t;

endpackage

>>> sv/pcb_ctrl.sv
module pcb_ctrl #(
  parameter int PROVIDERS = pcb_pkg::PROVIDERS_DEF,
  localparam int IDX_W = (PROVIDERS > 1) ? $clog2(PROVIDERS) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  output logic             out_valid,
  output pcb_pkg::cmd_t    cmd,
  output logic [IDX_W-1:0] scan_addr
);
  import pcb_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_READ  = 8'b0000_0010,
    S_PREP  = 8'b0000_0100,
    S_FOLD  = 8'b0000_1000,
    S_CAP   = 8'b0001_0000,
    S_WRITE = 8'b0010_0000,
    S_SCAN  = 8'b0100_0000,
    S_DRAIN = 8'b1000_0000
  } state_t;

  localparam logic [CAND_W-1:0] FOLD_LAST = CAND_W'(NUM_CAND - 1);
  localparam logic [IDX_W-1:0]  SCAN_LAST = IDX_W'(PROVIDERS - 1);

  state_t            state_r, state_nxt;
  logic [CAND_W-1:0] fold_r, fold_nxt;
  logic [IDX_W-1:0]  scan_r, scan_nxt;
  logic              out_valid_r;

  always_comb begin
    state_nxt = state_r;
    fold_nxt  = fold_r;
    scan_nxt  = scan_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_entry = 1'b1;
        state_nxt    = S_PREP;
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        fold_nxt  = '0;
        state_nxt = S_FOLD;
      end
      S_FOLD: begin
        cmd.fold     = 1'b1;
        cmd.fold_sel = fold_r;
        if (fold_r == FOLD_LAST) begin
          state_nxt = S_CAP;
        end else begin
          fold_nxt = fold_r + CAND_W'(1);
        end
      end
      S_CAP: begin
        cmd.cap   = 1'b1;
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        cmd.write    = 1'b1;
        cmd.scan_clr = 1'b1;
        scan_nxt     = '0;
        state_nxt    = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (scan_r == SCAN_LAST) begin
          state_nxt = S_DRAIN;
        end else begin
          scan_nxt = scan_r + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fold_r      <= '0;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fold_r      <= fold_nxt;
      scan_r      <= scan_nxt;
      out_valid_r <= (state_r == S_DRAIN);
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign scan_addr = scan_r;

endmodule

>>> sv/pcb_dp.sv
module pcb_dp #(
  parameter int PROVIDERS = pcb_pkg::PROVIDERS_DEF,
  localparam int IDX_W = (PROVIDERS > 1) ? $clog2(PROVIDERS) : 1
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  pcb_pkg::in_t                         in_word,
  input  pcb_pkg::cmd_t                        cmd,
  input  logic [IDX_W-1:0]                     scan_addr,
  input  logic                                 cfg_we,
  input  logic [pcb_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pcb_pkg::CFG_DATA_W-1:0]       cfg_data,
  output pcb_pkg::out_t                        out_word
);
  import pcb_pkg::*;

  function automatic logic [TIME_W-1:0] sat_time(input logic [TIME_W:0] t);
    sat_time = t[TIME_W] ? '1 : t[TIME_W-1:0];
  endfunction

  logic [IDX_W-1:0]  idx_map [PROV_SPAN];
  in_t               in_r;
  logic [IDX_W-1:0]  idx_r;
  logic [TIME_W:0]   now_x;

  logic [7:0]        thr_r;
  logic [15:0]       base_r;
  logic [SECS_W-1:0] bmax_r;
  logic [SECS_W-1:0] fb_r;
  logic [SECS_W-1:0] rmax_r;

  entry_t            mem [PROVIDERS];
  logic [PROVIDERS-1:0] vld_r;
  entry_t            ent_a_r;
  logic              vld_a_r;
  entry_t            cur;

  logic [TIME_W:0]   cand_r [NUM_CAND];
  logic [NUM_CAND-1:0] cv_r;
  logic [TIME_W:0]   nfb_r;
  logic [TIME_W:0]   nmx_r;
  logic [FAIL_W-1:0] fc_r;

  logic [TIME_W:0]   best_r;
  logic              have_r;
  logic [TIME_W:0]   pick;

  logic [FAIL_W-1:0] thr_x;
  logic [FAIL_W-1:0] esc_diff;
  logic              ge_r;
  logic [2:0]        esc_r;
  logic [SECS_W:0]   shifted;
  logic [SECS_W-1:0] cool_r;

  logic [TIME_W:0]   rate_base;
  logic [TIME_W:0]   rate_capped;
  logic [TIME_W-1:0] rate_until_r;
  logic [TIME_W-1:0] brk_until_r;

  entry_t            ent_nxt;
  entry_t            new_r;

  entry_t            ent_b_r;
  logic              vld_b_r;
  logic              live_b_r;
  logic [IDX_W-1:0]  idx_b_r;
  entry_t            eb;
  logic              hit;
  logic              sv_r;
  logic [TIME_W-1:0] su_r;
  logic [IDX_W-1:0]  sp_r;

  for (genvar g = 0; g < PROV_SPAN; g++) begin : g_map
    assign idx_map[g] = IDX_W'(g % PROVIDERS);
  end

  assign now_x = {1'b0, in_r.now};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_r  <= in_word;
      idx_r <= idx_map[in_word.provider];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THRESHOLD_RST;
      base_r <= BASE_RST;
      bmax_r <= BRK_MAX_RST;
      fb_r   <= FALLBACK_RST;
      rmax_r <= RATE_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_THRESHOLD: thr_r  <= cfg_data[7:0];
        CFG_BASE:      base_r <= cfg_data[15:0];
        CFG_BRK_MAX:   bmax_r <= cfg_data;
        CFG_FALLBACK:  fb_r   <= cfg_data;
        CFG_RATE_MAX:  rmax_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // entry memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem[idx_r] <= ent_nxt;
    end
    if (cmd.rd_entry) begin
      ent_a_r <= mem[idx_r];
    end
    if (cmd.scan_rd) begin
      ent_b_r <= mem[scan_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      vld_a_r  <= 1'b0;
      vld_b_r  <= 1'b0;
      live_b_r <= 1'b0;
    end else begin
      if (cmd.write) begin
        vld_r[idx_r] <= 1'b1;
      end
      if (cmd.rd_entry) begin
        vld_a_r <= vld_r[idx_r];
      end
      if (cmd.scan_rd) begin
        vld_b_r <= vld_r[scan_addr];
      end
      live_b_r <= cmd.scan_rd;
    end
  end

  assign cur = vld_a_r ? ent_a_r : '0;

  // candidate deadlines
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      cand_r[0] <= now_x + (TIME_W + 1)'(in_r.retry_secs);
      cand_r[1] <= {1'b0, in_r.req_reset_at};
      cand_r[2] <= {1'b0, in_r.tok_reset_at};
      cand_r[3] <= {1'b0, in_r.first_window_reset};
      cand_r[4] <= {1'b0, in_r.second_window_reset};
      cv_r[0]   <= (in_r.retry_secs != '0);
      cv_r[1]   <= (in_r.req_reset_at > in_r.now);
      cv_r[2]   <= (in_r.tok_reset_at > in_r.now);
      cv_r[3]   <= (in_r.window_count >= 2'd1) && in_r.first_window_full
                   && (in_r.first_window_reset > in_r.now);
      cv_r[4]   <= (in_r.window_count >= 2'd2) && in_r.second_window_full
                   && (in_r.second_window_reset > in_r.now);
      nfb_r     <= now_x + (TIME_W + 1)'(fb_r);
      nmx_r     <= now_x + (TIME_W + 1)'(rmax_r);
      fc_r      <= (cur.fails == FAIL_MAX) ? cur.fails : cur.fails + FAIL_W'(1);
    end
  end

  assign pick = cand_r[cmd.fold_sel];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (cmd.prep) begin
      have_r <= 1'b0;
    end else if (cmd.fold && cv_r[cmd.fold_sel]) begin
      have_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fold && cv_r[cmd.fold_sel] && (!have_r || pick > best_r)) begin
      best_r <= pick;
    end
  end

  // breaker backoff, settles over the fold cycles
  assign thr_x    = FAIL_W'(thr_r);
  assign esc_diff = fc_r - thr_x;
  assign shifted  = (SECS_W + 1)'(base_r) << esc_r;

  always_ff @(posedge clk) begin
    if (cmd.fold) begin
      ge_r   <= (fc_r >= thr_x);
      esc_r  <= (esc_diff > FAIL_W'(ESC_MAX)) ? ESC_MAX : esc_diff[2:0];
      cool_r <= (shifted > {1'b0, bmax_r}) ? bmax_r : shifted[SECS_W-1:0];
    end
  end

  assign rate_base   = have_r ? best_r : nfb_r;
  assign rate_capped = (rate_base > nmx_r) ? nmx_r : rate_base;

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      rate_until_r <= sat_time(rate_capped);
      brk_until_r  <= sat_time(now_x + (TIME_W + 1)'(cool_r));
    end
  end

  always_comb begin
    ent_nxt = cur;
    unique case (in_r.kind)
      KIND_REPORT: begin
        if (!in_r.limited) begin
          if (cur.st == ST_RATE) begin
            ent_nxt.st       = ST_NONE;
            ent_nxt.deadline = '0;
            ent_nxt.cause    = CAUSE_NONE;
          end
        end else if (cur.st != ST_RATE || rate_until_r > cur.deadline) begin
          ent_nxt.st       = ST_RATE;
          ent_nxt.deadline = rate_until_r;
          ent_nxt.cause    = (in_r.retry_secs != '0) ? CAUSE_RETRY :
                             (in_r.window_count != 2'd0) ? CAUSE_WINDOW : CAUSE_PLAIN;
        end
      end
      KIND_FAIL: begin
        ent_nxt.fails = fc_r;
        if (ge_r && cur.st != ST_RATE) begin
          ent_nxt.st       = ST_BREAK;
          ent_nxt.deadline = brk_until_r;
          ent_nxt.cause    = CAUSE_FAIL;
        end
      end
      KIND_PASS: begin
        ent_nxt = '0;
      end
      KIND_QUERY: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      new_r <= ent_nxt;
    end
  end

  // soonest rate-limit scan
  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      idx_b_r <= scan_addr;
    end
  end

  assign eb  = vld_b_r ? ent_b_r : '0;
  assign hit = live_b_r && (eb.st == ST_RATE) && (eb.deadline > in_r.now)
               && (!sv_r || eb.deadline < su_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= 1'b0;
      su_r <= '0;
      sp_r <= '0;
    end else if (cmd.scan_clr) begin
      sv_r <= 1'b0;
      su_r <= '0;
      sp_r <= '0;
    end else if (hit) begin
      sv_r <= 1'b1;
      su_r <= eb.deadline;
      sp_r <= idx_b_r;
    end
  end

  assign out_word.entry_state    = new_r.st;
  assign out_word.entry_until    = new_r.deadline;
  assign out_word.entry_failures = new_r.fails;
  assign out_word.entry_cause    = new_r.cause;
  assign out_word.soonest_valid  = sv_r;
  assign out_word.soonest_until  = su_r;
  assign out_word.soonest_idx    = PROV_W'(sp_r);

endmodule

>>> sv/provider_cooldown_breaker_unit.sv
// channel   ports                           handshake
// input     start, busy, in_word            taken when start is high and busy low
// result    out_valid, out_word             one-cycle strobe, no back-pressure
// config    cfg_we, cfg_index, cfg_data     written when cfg_we is high
//
// the strobe is registered off the drain state, which follows the read, prep, fold, cap,
// write and scan states; a new word can be taken in the strobe cycle, as busy is low again
// the scan of the entry memory reads one entry per cycle on its second read port
// synchronous reset clears the table valid bits and loads the register defaults
// the receiver cannot stall, results are never held
module provider_cooldown_breaker_unit #(
  parameter int PROVIDERS = pcb_pkg::PROVIDERS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  pcb_pkg::in_t                   in_word,
  output logic                           out_valid,
  output pcb_pkg::out_t                  out_word,
  input  logic                           cfg_we,
  input  logic [pcb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pcb_pkg::*;

  localparam int IDX_W = (PROVIDERS > 1) ? $clog2(PROVIDERS) : 1;

  cmd_t             cmd;
  logic [IDX_W-1:0] scan_addr;

  pcb_ctrl #(
    .PROVIDERS(PROVIDERS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .scan_addr (scan_addr)
  );

  pcb_dp #(
    .PROVIDERS(PROVIDERS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .scan_addr (scan_addr),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_word  (out_word)
  );

endmodule

>>> sv/pcb_checker.sv
module pcb_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_valid,
  input pcb_pkg::out_t out_word
);
  import pcb_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_strobe_ends_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result strobe outside end of work");

  a_soonest_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_word.soonest_valid) |->
      (out_word.soonest_until == '0 && out_word.soonest_idx == '0))
    else $error("soonest fields not cleared when none");

  a_entry_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.entry_state == ST_NONE) |->
      (out_word.entry_until == '0 && out_word.entry_cause == CAUSE_NONE))
    else $error("idle entry carries a deadline or cause");

endmodule

bind provider_cooldown_breaker_unit pcb_checker u_pcb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_word  (out_word)
);

>>> test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pcb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 40;
  localparam int PRINT_CAP   = 40;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  logic                  busy;
  in_t                   in_word   = '0;
  logic                  out_valid;
  out_t                  out_word;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // shadow of the cooldown table and registers
  logic [1:0]        tbl_state [PROV_SPAN];
  logic [TIME_W-1:0] tbl_until [PROV_SPAN];
  logic [FAIL_W-1:0] tbl_fails [PROV_SPAN];
  logic [2:0]        tbl_cause [PROV_SPAN];
  logic [7:0]        thr_reg      = THRESHOLD_RST;
  logic [15:0]       base_reg     = BASE_RST;
  logic [SECS_W-1:0] brk_max_reg  = BRK_MAX_RST;
  logic [SECS_W-1:0] fallback_reg = FALLBACK_RST;
  logic [SECS_W-1:0] rate_max_reg = RATE_MAX_RST;

  out_t              pending_status [$];
  int                mismatches     = 0;
  int                words_sent     = 0;
  int                status_checked = 0;
  int                settings_used  = 0;
  int                cycles         = 0;

  provider_cooldown_breaker_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  initial begin
    for (int i = 0; i < PROV_SPAN; i++) begin
      tbl_state[i] = ST_NONE;
      tbl_until[i] = '0;
      tbl_fails[i] = '0;
      tbl_cause[i] = CAUSE_NONE;
    end
  end

  function automatic out_t predict_cooldown(in_t w);
    out_t        res;
    int          p;
    int          esc;
    logic [63:0] t_now;
    logic [63:0] best;
    logic [63:0] span;
    logic [63:0] cand [5];
    bit          have;
    p     = int'(w.provider) % PROV_SPAN;
    t_now = 64'(w.now);
    case (w.kind)
      KIND_REPORT: begin
        if (!w.limited) begin
          if (tbl_state[p] == ST_RATE) begin
            tbl_state[p] = ST_NONE;
            tbl_until[p] = '0;
            tbl_cause[p] = CAUSE_NONE;
          end
        end else begin
          cand[0] = (w.retry_secs != 0) ? t_now + 64'(w.retry_secs) : 64'd0;
          cand[1] = 64'(w.req_reset_at);
          cand[2] = 64'(w.tok_reset_at);
          cand[3] = (w.window_count >= 1 && w.first_window_full) ?
                    64'(w.first_window_reset) : 64'd0;
          cand[4] = (w.window_count >= 2 && w.second_window_full) ?
                    64'(w.second_window_reset) : 64'd0;
          have = 1'b0;
          best = '0;
          for (int i = 0; i < 5; i++) begin
            if (cand[i] > t_now) begin
              if (!have || cand[i] > best) best = cand[i];
              have = 1'b1;
            end
          end
          if (!have) best = t_now + 64'(fallback_reg);
          if (best > t_now + 64'(rate_max_reg)) best = t_now + 64'(rate_max_reg);
          if (best > 64'hFFFF_FFFF) best = 64'hFFFF_FFFF;
          if (tbl_state[p] != ST_RATE || best > 64'(tbl_until[p])) begin
            tbl_state[p] = ST_RATE;
            tbl_until[p] = best[31:0];
            if (w.retry_secs != 0) tbl_cause[p] = CAUSE_RETRY;
            else if (w.window_count != 0) tbl_cause[p] = CAUSE_WINDOW;
            else tbl_cause[p] = CAUSE_PLAIN;
          end
        end
      end
      KIND_FAIL: begin
        if (tbl_fails[p] != FAIL_MAX) tbl_fails[p] = tbl_fails[p] + 1'b1;
        if (tbl_fails[p] >= 16'(thr_reg) && tbl_state[p] != ST_RATE) begin
          esc = int'(tbl_fails[p]) - int'(thr_reg);
          if (esc > int'(ESC_MAX)) esc = int'(ESC_MAX);
          span = 64'(base_reg) << esc;
          if (span > 64'(brk_max_reg)) span = 64'(brk_max_reg);
          span = t_now + span;
          if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
          tbl_state[p] = ST_BREAK;
          tbl_until[p] = span[31:0];
          tbl_cause[p] = CAUSE_FAIL;
        end
      end
      KIND_PASS: begin
        tbl_state[p] = ST_NONE;
        tbl_until[p] = '0;
        tbl_fails[p] = '0;
        tbl_cause[p] = CAUSE_NONE;
      end
      default: ;
    endcase
    res = '0;
    for (int i = 0; i < PROV_SPAN; i++) begin
      if (tbl_state[i] == ST_RATE && 64'(tbl_until[i]) > t_now &&
          (!res.soonest_valid || tbl_until[i] < res.soonest_until)) begin
        res.soonest_valid = 1'b1;
        res.soonest_until = tbl_until[i];
        res.soonest_idx   = PROV_W'(i);
      end
    end
    res.entry_state    = tbl_state[p];
    res.entry_until    = tbl_until[p];
    res.entry_failures = tbl_fails[p];
    res.entry_cause    = tbl_cause[p];
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("word %0d %s got %0h want %0h",
                                status_checked, name, got, want));
  endtask

  // results cannot be held off, so every strobe is taken at its edge
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid) begin
      if (pending_status.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        want = pending_status.pop_front();
        compare_field("entry_state", 32'(out_word.entry_state), 32'(want.entry_state));
        compare_field("entry_until", out_word.entry_until, want.entry_until);
        compare_field("entry_failures", 32'(out_word.entry_failures),
                      32'(want.entry_failures));
        compare_field("entry_cause", 32'(out_word.entry_cause), 32'(want.entry_cause));
        compare_field("soonest_valid", 32'(out_word.soonest_valid),
                      32'(want.soonest_valid));
        compare_field("soonest_until", out_word.soonest_until, want.soonest_until);
        compare_field("soonest_idx", 32'(out_word.soonest_idx),
                      32'(want.soonest_idx));
      end
      status_checked++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // leaves start high so back-to-back words need no second assignment
  task automatic send_word(in_t w);
    in_word <= w;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_status.push_back(predict_cooldown(w));
    words_sent++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_status.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      CFG_THRESHOLD: thr_reg      = data[7:0];
      CFG_BASE:      base_reg     = data[15:0];
      CFG_BRK_MAX:   brk_max_reg  = data;
      CFG_FALLBACK:  fallback_reg = data;
      CFG_RATE_MAX:  rate_max_reg = data;
      default: ;
    endcase
  endtask

  function automatic in_t blank_item(logic [1:0] kind, int prov, logic [TIME_W-1:0] t);
    in_t w;
    w          = '0;
    w.kind     = kind;
    w.provider = PROV_W'(prov);
    w.now      = t;
    w.limited  = 1'b1;
    return w;
  endfunction

  function automatic logic [TIME_W-1:0] near_time(logic [TIME_W-1:0] t);
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return t - TIME_W'($urandom_range(0, 200));
      4:       return TIME_W'($urandom);
      default: return t + TIME_W'($urandom_range(1, 4000));
    endcase
  endfunction

  function automatic in_t rand_item(logic [TIME_W-1:0] t);
    in_t w;
    int  r;
    r = $urandom_range(0, 9);
    if (r < 4) w.kind = KIND_REPORT;
    else if (r < 7) w.kind = KIND_FAIL;
    else if (r == 7) w.kind = KIND_PASS;
    else w.kind = KIND_QUERY;
    // a few hot entries so failures pile up
    w.provider = $urandom_range(0, 1) ? PROV_W'($urandom_range(0, 3)) :
                                        PROV_W'($urandom_range(0, 15));
    w.now     = ($urandom_range(0, 19) == 0) ? TIME_W'($urandom) : t;
    w.limited = ($urandom_range(0, 7) != 0);
    case ($urandom_range(0, 4))
      0, 1:    w.retry_secs = '0;
      2, 3:    w.retry_secs = SECS_W'($urandom_range(1, 300));
      default: w.retry_secs = SECS_W'($urandom);
    endcase
    w.req_reset_at        = near_time(t);
    w.tok_reset_at        = near_time(t);
    w.window_count        = 2'($urandom_range(0, 3));
    w.first_window_reset  = near_time(t);
    w.first_window_full   = 1'($urandom_range(0, 1));
    w.second_window_reset = near_time(t);
    w.second_window_full  = 1'($urandom_range(0, 1));
    return w;
  endfunction

  task automatic test_rate_reports();
    in_t w;
    w = blank_item(KIND_REPORT, 1, 32'd1000);
    w.retry_secs = 20'd100;
    send_word(w);
    w = blank_item(KIND_REPORT, 2, 32'd1000);
    w.req_reset_at = 32'd1500;
    w.tok_reset_at = 32'd1300;
    send_word(w);
    w = blank_item(KIND_REPORT, 3, 32'd1000);
    w.window_count        = 2'd2;
    w.first_window_reset  = 32'd2000;
    w.first_window_full   = 1'b1;
    w.second_window_reset = 32'd2500;
    w.second_window_full  = 1'b1;
    send_word(w);
    // second window ignored when only one is reported
    w = blank_item(KIND_REPORT, 4, 32'd1000);
    w.window_count        = 2'd1;
    w.first_window_reset  = 32'd1800;
    w.first_window_full   = 1'b1;
    w.second_window_reset = 32'd9000;
    w.second_window_full  = 1'b1;
    send_word(w);
    // window count of three, first window not saturated
    w = blank_item(KIND_REPORT, 10, 32'd1000);
    w.window_count        = 2'd3;
    w.first_window_reset  = 32'd5000;
    w.second_window_reset = 32'd1700;
    w.second_window_full  = 1'b1;
    send_word(w);
    // only past reset times, so the fallback applies
    w = blank_item(KIND_REPORT, 5, 32'd1000);
    w.req_reset_at = 32'd500;
    w.tok_reset_at = 32'd1000;
    send_word(w);
    w = blank_item(KIND_REPORT, 6, 32'd1000);
    w.retry_secs = 20'hFFFFF;
    send_word(w);
    // shorter deadline must not shorten the cooldown
    w = blank_item(KIND_REPORT, 1, 32'd1010);
    w.retry_secs = 20'd50;
    send_word(w);
    w = blank_item(KIND_REPORT, 2, 32'd1010);
    w.limited = 1'b0;
    send_word(w);
    w = blank_item(KIND_REPORT, 7, 32'd1010);
    w.limited = 1'b0;
    send_word(w);
    // deadline saturates at the top of the time range
    w = blank_item(KIND_REPORT, 8, 32'hFFFF_FF00);
    w.retry_secs = 20'hFFFFF;
    send_word(w);
    w = blank_item(KIND_QUERY, 0, 32'hFFFF_FFFF);
    send_word(w);
  endtask

  task automatic test_breaker_backoff();
    in_t w;
    for (int i = 0; i < 4; i++) begin
      w = blank_item(KIND_FAIL, 9, 32'd2000 + 32'(i));
      send_word(w);
    end
    // a rate limit owns the cooldown, only the count moves
    for (int i = 0; i < 3; i++) begin
      w = blank_item(KIND_FAIL, 1, 32'd1020);
      send_word(w);
    end
    w = blank_item(KIND_PASS, 9, 32'd2010);
    send_word(w);
    w = '1;
    w.kind = KIND_QUERY;
    send_word(w);
    w = blank_item(KIND_QUERY, 1, 32'd1020);
    send_word(w);
  endtask

  task automatic test_traffic_under_settings();
    in_t               w;
    logic [19:0]       thr, base, bmax, fb, rmax;
    int                burst_left;
    logic [TIME_W-1:0] t;
    burst_left = 0;
    for (int ph = 0; ph < 6; ph++) begin
      t = TIME_W'($urandom_range(1000, 32'h7FFF_FFFF));
      case (ph)
        0: begin
          thr = 20'(THRESHOLD_RST); base = 20'(BASE_RST);
          bmax = BRK_MAX_RST; fb = FALLBACK_RST; rmax = RATE_MAX_RST;
        end
        1: begin
          thr = 20'd1; base = 20'd1; bmax = 20'd1; fb = 20'd1; rmax = 20'd1;
        end
        2: begin
          thr = 20'd255; base = 20'd65535; bmax = 20'hFFFFF; fb = 20'hFFFFF;
          rmax = 20'hFFFFF;
          t = 32'hFFFF_F000;
        end
        3: begin
          thr = 20'd0; base = 20'd65535; bmax = 20'hFFFFF; fb = 20'd0; rmax = 20'd0;
        end
        default: begin
          // upper bits beyond each register's width must be dropped
          thr  = (20'($urandom) & 20'hFFF00) | 20'($urandom_range(0, 6));
          base = (20'($urandom) & 20'hF0000) | 20'($urandom_range(0, 300));
          bmax = 20'($urandom_range(0, 5000));
          fb   = 20'($urandom_range(0, 500));
          rmax = 20'($urandom_range(0, 8000));
        end
      endcase
      wait_idle();
      cfg_write(CFG_THRESHOLD, thr);
      cfg_write(CFG_BASE, base);
      cfg_write(CFG_BRK_MAX, bmax);
      cfg_write(CFG_FALLBACK, fb);
      cfg_write(CFG_RATE_MAX, rmax);
      cfg_write(CFG_IDX_W'(CFG_RATE_MAX + 1 + $urandom_range(0, 2)), 20'($urandom));
      cfg_we <= 1'b0;
      @(posedge clk);
      settings_used++;
      for (int n = 0; n < 75; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          if ($urandom_range(0, 3) != 0) begin
            start   <= 1'b0;
            in_word <= rand_item(t);
            repeat ($urandom_range(1, 40)) @(posedge clk);
          end
        end
        burst_left--;
        t = t + TIME_W'($urandom_range(0, 40));
        w = rand_item(t);
        send_word(w);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_rate_reports();
    test_breaker_backoff();
    test_traffic_under_settings();
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("sent %0d words, checked %0d result words", words_sent, status_checked);
    $display("reset values plus %0d register settings, extremes included", settings_used);
    if (mismatches == 0 && pending_status.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> provider_cooldown_breaker_unit.f
sv/pcb_pkg.sv
sv/pcb_ctrl.sv
sv/pcb_dp.sv
sv/provider_cooldown_breaker_unit.sv
sv/pcb_checker.sv
test/tb_top.sv
